[rtl/bpl_pkg.sv]
`default_nettype none

package bpl_pkg;

	localparam int DATA_W    = 32;
	localparam int POS_IN_W  = 5;
	localparam int CNT_OUT_W = 5;
	localparam int POS_W     = 9;
	localparam int IN_W      = 40;
	localparam int OUT_W     = 40;

	typedef enum logic [2:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_BACK   = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_INSERT     = 3'd4,
		OP_GET        = 3'd5,
		OP_FRONT      = 3'd6,
		OP_BACK       = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic             ins;
		logic             rem;
		logic [POS_W-1:0] at;
	} chain_ctl_t;

	typedef struct packed {
		status_t          status;
		logic             rd_ok;
		logic             rd_err;
		logic [POS_W-1:0] rd_at;
	} resp_t;

endpackage

`default_nettype wire

[rtl/bounded_positional_list.sv]
// Channel   Direction  Fields (tdata, lowest bit first)
// s_axis    in         op[2:0], value[34:3], pos[39:35]
// m_axis    out        data[31:0], status[33:32], count[38:34], is_empty[39]
//
// For each item, the cell chain shifts, loads or is read in the
// cycle the item is accepted, and the result lands in the output register.
// A new item is accepted in every cycle in which the output register is empty
// or its item is taken. The count is cleared by reset; cell contents are not.
`default_nettype none

module bounded_positional_list #(
	parameter int DEPTH = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_axis_tvalid,
	output logic                            s_axis_tready,
	input  wire logic [bpl_pkg::IN_W-1:0]   s_axis_tdata,  // op, value, pos
	output logic                            m_axis_tvalid,
	input  wire logic                       m_axis_tready,
	output logic      [bpl_pkg::OUT_W-1:0]  m_axis_tdata   // data, status, count, is_empty
);
	import bpl_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);

	logic                 in_acc;
	op_t                  in_op;
	logic [DATA_W-1:0]    in_value;
	logic [POS_IN_W-1:0]  in_pos;
	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        cnt_next;
	chain_ctl_t           ctl;
	chain_ctl_t           ctl_g;
	resp_t                resp;
	logic [DATA_W-1:0]    cell_q [DEPTH];
	logic [DATA_W-1:0]    rd_word;
	logic [DATA_W-1:0]    res_data;
	logic                 m_valid_q;
	logic [OUT_W-1:0]     m_data_q;

	assign in_op    = op_t'(s_axis_tdata[2:0]);
	assign in_value = s_axis_tdata[34:3];
	assign in_pos   = s_axis_tdata[39:35];

	assign s_axis_tready = !m_valid_q || m_axis_tready;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	bpl_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.op  (in_op),
		.pos (in_pos),
		.cnt (POS_W'(cnt_q)),
		.ctl (ctl),
		.resp(resp)
	);

	assign ctl_g = in_acc ? ctl : '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		bpl_cell #(
			.IDX(i)
		) u_cell (
			.clk  (clk),
			.ctl  (ctl_g),
			.value(in_value),
			.left ((i == 0) ? '0 : cell_q[(i == 0) ? 0 : i - 1]),
			.right((i == DEPTH - 1) ? '0 : cell_q[(i == DEPTH - 1) ? i : i + 1]),
			.q    (cell_q[i])
		);
	end

	assign rd_word  = cell_q[resp.rd_at[IW-1:0]];
	assign res_data = resp.rd_ok ? rd_word : (resp.rd_err ? '1 : '0);

	always_comb begin
		cnt_next = cnt_q;
		if (ctl.ins) begin
			cnt_next = cnt_q + CW'(1);
		end else if (ctl.rem) begin
			cnt_next = cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
		end else if (in_acc) begin
			cnt_q     <= cnt_next;
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			m_data_q <= {cnt_next == '0, CNT_OUT_W'(cnt_next), resp.status, res_data};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("entry count exceeds depth");

	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_acc |=> $stable(cnt_q))
		else $error("entry count changed without an accepted item");

	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && ctl.ins) |=> cnt_q == CW'($past(cnt_q) + 1'b1))
		else $error("insert did not grow the list");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && cnt_q == '0 && (in_op == OP_POP_FRONT || in_op == OP_POP_BACK))
		|=> m_axis_tdata[33:32] == ST_RANGE)
		else $error("pop on empty list not reported");

	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> m_axis_tvalid)
		else $error("accepted item produced no result");
`endif

endmodule

`default_nettype wire

[rtl/bpl_cell.sv]
`default_nettype none

module bpl_cell #(
	parameter int IDX = 0
) (
	input  wire logic                      clk,
	input  wire bpl_pkg::chain_ctl_t       ctl,
	input  wire logic [bpl_pkg::DATA_W-1:0] value,
	input  wire logic [bpl_pkg::DATA_W-1:0] left,
	input  wire logic [bpl_pkg::DATA_W-1:0] right,
	output logic      [bpl_pkg::DATA_W-1:0] q
);
	import bpl_pkg::*;

	logic [POS_W-1:0] my_idx;

	assign my_idx = POS_W'(IDX);

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (my_idx == ctl.at) begin
				q <= value;
			end else if (my_idx > ctl.at) begin
				q <= left;
			end
		end else if (ctl.rem) begin
			if (my_idx >= ctl.at) begin
				q <= right;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/bpl_ctrl.sv]
`default_nettype none

module bpl_ctrl #(
	parameter int DEPTH = 16
) (
	input  wire bpl_pkg::op_t                 op,
	input  wire logic [bpl_pkg::POS_IN_W-1:0] pos,
	input  wire logic [bpl_pkg::POS_W-1:0]    cnt,
	output bpl_pkg::chain_ctl_t               ctl,
	output bpl_pkg::resp_t                    resp
);
	import bpl_pkg::*;

	logic             full;
	logic             empty;
	logic [POS_W-1:0] last;
	logic [POS_W-1:0] pos_x;

	assign full  = cnt >= POS_W'(DEPTH);
	assign empty = cnt == '0;
	assign last  = cnt - POS_W'(1);
	assign pos_x = POS_W'(pos);

	always_comb begin
		ctl         = '0;
		resp.status = ST_OK;
		resp.rd_ok  = 1'b0;
		resp.rd_err = 1'b0;
		resp.rd_at  = '0;
		case (op)
			OP_PUSH_BACK: begin
				if (full) begin
					resp.status = ST_FULL;
				end else begin
					ctl.ins = 1'b1;
					ctl.at  = cnt;
				end
			end
			OP_PUSH_FRONT: begin
				if (full) begin
					resp.status = ST_FULL;
				end else begin
					ctl.ins = 1'b1;
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					resp.status = ST_RANGE;
				end else begin
					ctl.rem = 1'b1;
					ctl.at  = last;
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					resp.status = ST_RANGE;
				end else begin
					ctl.rem = 1'b1;
				end
			end
			OP_INSERT: begin
				if (pos_x > cnt) begin
					resp.status = ST_RANGE;
				end else if (full) begin
					resp.status = ST_FULL;
				end else begin
					ctl.ins = 1'b1;
					ctl.at  = pos_x;
				end
			end
			OP_GET: begin
				resp.rd_at = pos_x;
				if (pos_x < cnt) begin
					resp.rd_ok = 1'b1;
				end else begin
					resp.rd_err = 1'b1;
					resp.status = ST_RANGE;
				end
			end
			OP_FRONT: begin
				if (empty) begin
					resp.rd_err = 1'b1;
					resp.status = ST_RANGE;
				end else begin
					resp.rd_ok = 1'b1;
				end
			end
			OP_BACK: begin
				resp.rd_at = last;
				if (empty) begin
					resp.rd_err = 1'b1;
					resp.status = ST_RANGE;
				end else begin
					resp.rd_ok = 1'b1;
				end
			end
			default: begin
				resp.status = ST_RANGE;
			end
		endcase
	end

endmodule

`default_nettype wire
